@@ rtl/ract_pkg.sv @@
package ract_pkg;

   localparam int TABLE_SLOTS_DEF = 1024;
   localparam int REF_WIDTH_DEF   = 16;

   localparam logic [31:0] HASH_SEED      = 32'd177573;
   localparam logic [15:0] BASE_AGE_RST   = 16'd600;
   localparam logic [41:0] MAX_BYTES_RST  = 42'd1000000000;
   localparam logic [10:0] MAX_ENTRY_RST  = 11'd1024;

   typedef enum logic [1:0] {
      OP_MAP   = 2'd0,
      OP_UNMAP = 2'd1,
      OP_SWEEP = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_RELEASED = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_ZERO     = 3'd5,
      ST_SWEPT    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_BASE_AGE  = 2'd0,
      CSR_MAX_BYTES = 2'd1,
      CSR_MAX_ENTRY = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_UNMAP_RD,
      S_UNMAP_CHK,
      S_SWEEP_RD,
      S_SWEEP_CHK,
      S_AGE_MUL,
      S_AGE_DIV,
      S_AGE_SEL
   } state_type;

   // one shift-add-xor mixing round
   function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] k);
      logic [31:0] t;
      t = h + (h << 5);
      return t ^ k;
   endfunction

endpackage

@@ rtl/refcounted_aging_cache_table.sv @@
// Channel   | Ports                                    | Handshake
// ----------+------------------------------------------+----------------------------
// request   | req_operation .. req_handle              | start & !busy
// response  | rsp_status .. rsp_age_limit              | rsp_valid, one cycle
// csr       | csr_write, csr_index, csr_data           | csr_write, no wait
//
// After reset the valid bits are cleared by a pass over all TABLE_SLOTS slots, busy high.
// A map hashes, then reads and checks slot by slot (one memory read per slot).
// An unmap reads and checks one slot. A sweep checks each slot, then updates the age.
// Each transaction gives one response strobe; operation 3 gives none.
// The receiver cannot stall; busy holds off new transactions.
module refcounted_aging_cache_table #(
   parameter int TABLE_SLOTS = ract_pkg::TABLE_SLOTS_DEF,
   parameter int REF_WIDTH   = ract_pkg::REF_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_file_id,
   input  logic [31:0] req_device_id,
   input  logic [31:0] req_file_size,
   input  logic [31:0] req_change_time,
   input  logic [31:0] req_now,
   input  logic [9:0]  req_handle,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_slot,
   output logic [15:0] rsp_ref_count,
   output logic [10:0] rsp_freed_entries,
   output logic [10:0] rsp_active_entries,
   output logic [41:0] rsp_bytes_held,
   output logic [17:0] rsp_age_limit,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [41:0] csr_data
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam int EW = 128 + REF_WIDTH + 32;
   localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

   // entry memory: keys, count, stamp; valid bits in their own memory
   logic [EW-1:0] ent_mem [TABLE_SLOTS];
   logic          vld_mem [TABLE_SLOTS];

   logic [EW-1:0] ent_rd_ff;
   logic          vld_rd_ff;
   logic [AW-1:0] rd_addr;
   logic          ent_we, vld_we, vld_wd;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] ent_wd;

   always_ff @(posedge clock) begin
      ent_rd_ff <= ent_mem[rd_addr];
      vld_rd_ff <= vld_mem[rd_addr];
      if (ent_we) begin
         ent_mem[wr_addr] <= ent_wd;
      end
      if (vld_we) begin
         vld_mem[wr_addr] <= vld_wd;
      end
   end

   ract_pkg::state_type state_ff, state_in;

   logic [15:0] base_ff;
   logic [41:0] max_bytes_ff;
   logic [10:0] max_ent_ff;
   logic [17:0] age_ff, age_in;
   logic [CW-1:0] total_ff, total_in;
   logic [41:0] bytes_ff, bytes_in;

   // base age over ten by reciprocal multiplication, exact for 16 bits
   logic [31:0] base_scaled;
   logic [15:0] base_tenth;
   assign base_scaled = {16'd0, base_ff} * 32'd52429;
   assign base_tenth  = {3'd0, base_scaled[31:19]};

   logic [31:0] kf_ff, kd_ff, ks_ff, kc_ff, now_ff;
   logic [9:0]  handle_ff;
   logic [31:0] hash_ff, hash_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] freed_ff, freed_in;
   logic [19:0] prod_ff, prod_in;
   logic [19:0] quo_ff, quo_in;
   logic        shrink_ff, shrink_in, grow_ff, grow_in;

   logic        rsp_valid_in;
   logic [2:0]  rsp_status_in;
   logic [9:0]  rsp_slot_in;
   logic [15:0] rsp_ref_in;
   logic [10:0] rsp_freed_in;

   logic accept;
   assign accept = start && !busy;

   // fields of the entry read back
   logic [31:0] e_file, e_dev, e_size, e_ctime, e_stamp;
   logic [REF_WIDTH-1:0] e_refs;
   assign {e_file, e_dev, e_size, e_ctime, e_refs, e_stamp} = ent_rd_ff;

   logic key_eq;
   assign key_eq = (e_file == kf_ff) && (e_dev == kd_ff) && (e_size == ks_ff)
                   && (e_ctime == kc_ff);

   logic expire;
   assign expire = vld_rd_ff && (e_refs == '0) && (now_ff >= e_stamp)
                   && ((now_ff - e_stamp) >= {14'd0, age_ff});

   logic [REF_WIDTH-1:0] refs_inc, refs_dec;
   assign refs_inc = (e_refs == REF_MAX) ? e_refs : e_refs + 1'b1;
   assign refs_dec = e_refs - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ract_pkg::S_CLEAR:
            if (idx_ff == AW'(TABLE_SLOTS - 1)) state_in = ract_pkg::S_IDLE;
         ract_pkg::S_IDLE:
            if (accept) begin
               unique case (ract_pkg::op_type'(req_operation))
                  ract_pkg::OP_MAP:   state_in = ract_pkg::S_HASH;
                  ract_pkg::OP_UNMAP: state_in = ract_pkg::S_UNMAP_RD;
                  ract_pkg::OP_SWEEP: state_in = ract_pkg::S_SWEEP_RD;
                  default:            state_in = ract_pkg::S_IDLE;
               endcase
            end
         ract_pkg::S_HASH:      state_in = ract_pkg::S_PROBE_RD;
         ract_pkg::S_PROBE_RD:  state_in = ract_pkg::S_PROBE_CHK;
         ract_pkg::S_PROBE_CHK:
            if (!vld_rd_ff || key_eq || cnt_ff == CW'(TABLE_SLOTS - 1))
               state_in = ract_pkg::S_IDLE;
            else
               state_in = ract_pkg::S_PROBE_RD;
         ract_pkg::S_UNMAP_RD:
            state_in = ract_pkg::S_UNMAP_CHK;
         ract_pkg::S_UNMAP_CHK: state_in = ract_pkg::S_IDLE;
         ract_pkg::S_SWEEP_RD:  state_in = ract_pkg::S_SWEEP_CHK;
         ract_pkg::S_SWEEP_CHK:
            if (idx_ff == AW'(TABLE_SLOTS - 1)) state_in = ract_pkg::S_AGE_MUL;
            else                                 state_in = ract_pkg::S_SWEEP_RD;
         ract_pkg::S_AGE_MUL:   state_in = ract_pkg::S_AGE_DIV;
         ract_pkg::S_AGE_DIV:   state_in = ract_pkg::S_AGE_SEL;
         ract_pkg::S_AGE_SEL:   state_in = ract_pkg::S_IDLE;
         default:               state_in = ract_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rd_addr       = idx_ff;
      ent_we        = 1'b0;
      vld_we        = 1'b0;
      vld_wd        = 1'b0;
      wr_addr       = idx_ff;
      ent_wd        = ent_rd_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      hash_in       = hash_ff;
      freed_in      = freed_ff;
      total_in      = total_ff;
      bytes_in      = bytes_ff;
      age_in        = age_ff;
      prod_in       = prod_ff;
      quo_in        = quo_ff;
      shrink_in     = shrink_ff;
      grow_in       = grow_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ract_pkg::ST_HIT;
      rsp_slot_in   = '0;
      rsp_ref_in    = '0;
      rsp_freed_in  = '0;
      unique case (state_ff)
         ract_pkg::S_CLEAR: begin
            vld_we = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ract_pkg::S_IDLE: begin
            if (accept) begin
               hash_in  = ract_pkg::mix(ract_pkg::mix(ract_pkg::HASH_SEED ^ req_file_id,
                                                      req_device_id), req_file_size);
               idx_in   = '0;
               cnt_in   = '0;
               freed_in = '0;
            end
         end
         ract_pkg::S_HASH: begin
            idx_in = AW'(ract_pkg::mix(hash_ff, kc_ff));
         end
         ract_pkg::S_PROBE_RD: ;
         ract_pkg::S_PROBE_CHK: begin
            if (!vld_rd_ff) begin
               vld_we = 1'b1;
               vld_wd = 1'b1;
               ent_we = 1'b1;
               ent_wd = {kf_ff, kd_ff, ks_ff, kc_ff, REF_WIDTH'(1), now_ff};
               total_in = total_ff + 1'b1;
               bytes_in = bytes_ff + {10'd0, ks_ff};
               rsp_valid_in  = 1'b1;
               rsp_status_in = ract_pkg::ST_INSERTED;
               rsp_slot_in   = 10'(idx_ff);
               rsp_ref_in    = 16'(REF_WIDTH'(1));
            end else if (key_eq) begin
               ent_we = 1'b1;
               ent_wd = {e_file, e_dev, e_size, e_ctime, refs_inc, now_ff};
               rsp_valid_in  = 1'b1;
               rsp_status_in = ract_pkg::ST_HIT;
               rsp_slot_in   = 10'(idx_ff);
               rsp_ref_in    = 16'(refs_inc);
            end else if (cnt_ff == CW'(TABLE_SLOTS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ract_pkg::ST_FULL;
            end else begin
               idx_in = idx_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ract_pkg::S_UNMAP_RD: ;
         ract_pkg::S_UNMAP_CHK: begin
            rsp_valid_in = 1'b1;
            if ({22'd0, handle_ff} >= 32'(TABLE_SLOTS) || !vld_rd_ff) begin
               rsp_status_in = ract_pkg::ST_NOTFOUND;
            end else if (e_refs == '0) begin
               rsp_status_in = ract_pkg::ST_ZERO;
            end else begin
               ent_we = 1'b1;
               ent_wd = {e_file, e_dev, e_size, e_ctime, refs_dec, now_ff};
               rsp_status_in = ract_pkg::ST_RELEASED;
               rsp_ref_in    = 16'(refs_dec);
            end
         end
         ract_pkg::S_SWEEP_RD: ;
         ract_pkg::S_SWEEP_CHK: begin
            if (expire) begin
               vld_we   = 1'b1;
               total_in = total_ff - 1'b1;
               bytes_in = bytes_ff - {10'd0, e_size};
               freed_in = freed_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         ract_pkg::S_AGE_MUL: begin
            shrink_in = (bytes_ff > max_bytes_ff)
                        || ({{(32-CW){1'b0}}, total_ff} > {21'd0, max_ent_ff});
            grow_in   = {{(32-CW){1'b0}}, total_ff} < {22'd0, max_ent_ff[10:1]};
            if (shrink_in) prod_in = {1'b0, age_ff, 1'b0};
            else           prod_in = {2'd0, age_ff} + {age_ff, 2'b00};
         end
         ract_pkg::S_AGE_DIV: begin
            // shrink: divide by three via reciprocal, correct once; else divide by four
            if (shrink_ff) begin
               quo_in = 20'((({20'd0, prod_ff} * 40'd349526) >> 20));
               if (prod_ff - quo_in * 20'd3 >= 20'd3) quo_in = quo_in + 1'b1;
            end else begin
               quo_in = prod_ff >> 2;
            end
         end
         ract_pkg::S_AGE_SEL: begin
            if (shrink_ff) begin
               if (quo_ff > {4'd0, base_tenth}) age_in = 18'(quo_ff);
               else age_in = {2'd0, base_tenth};
            end else if (grow_ff) begin
               if (quo_ff < 20'(base_ff) * 20'd3) age_in = 18'(quo_ff);
               else age_in = 18'(base_ff * 18'd3);
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = ract_pkg::ST_SWEPT;
            rsp_freed_in  = 11'(freed_ff);
         end
         default: ;
      endcase
      if (state_ff == ract_pkg::S_IDLE && accept
          && ract_pkg::op_type'(req_operation) == ract_pkg::OP_UNMAP)
         idx_in = AW'(req_handle);
      rd_addr = idx_in;
   end

   // state, counter and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ract_pkg::S_CLEAR;
         idx_ff       <= '0;
         base_ff      <= ract_pkg::BASE_AGE_RST;
         max_bytes_ff <= ract_pkg::MAX_BYTES_RST;
         max_ent_ff   <= ract_pkg::MAX_ENTRY_RST;
         age_ff       <= 18'(ract_pkg::BASE_AGE_RST);
         total_ff     <= '0;
         bytes_ff     <= '0;
         rsp_valid    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         age_ff    <= age_in;
         total_ff  <= total_in;
         bytes_ff  <= bytes_in;
         rsp_valid <= rsp_valid_in;
         if (csr_write) begin
            case (ract_pkg::csr_type'(csr_index))
               ract_pkg::CSR_BASE_AGE:  base_ff      <= csr_data[15:0];
               ract_pkg::CSR_MAX_BYTES: max_bytes_ff <= csr_data;
               ract_pkg::CSR_MAX_ENTRY: max_ent_ff   <= csr_data[10:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kf_ff     <= req_file_id;
         kd_ff     <= req_device_id;
         ks_ff     <= req_file_size;
         kc_ff     <= req_change_time;
         now_ff    <= req_now;
         handle_ff <= req_handle;
      end
      hash_ff   <= hash_in;
      cnt_ff    <= cnt_in;
      freed_ff  <= freed_in;
      prod_ff   <= prod_in;
      quo_ff    <= quo_in;
      shrink_ff <= shrink_in;
      grow_ff   <= grow_in;
      rsp_status        <= rsp_status_in;
      rsp_slot          <= rsp_slot_in;
      rsp_ref_count     <= rsp_ref_in;
      rsp_freed_entries <= rsp_freed_in;
   end

   assign busy = (state_ff != ract_pkg::S_IDLE);
   assign rsp_active_entries = 11'(total_ff);
   assign rsp_bytes_held     = bytes_ff;
   assign rsp_age_limit      = age_ff;

endmodule

@@ tb/sv/tb_refcounted_aging_cache_table.sv @@
module tb_refcounted_aging_cache_table;

   localparam int SLOTS   = 1024;
   localparam int REF_MAX = 65535;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = ract_pkg::OP_MAP;
   logic [31:0] req_file_id = '0;
   logic [31:0] req_device_id = '0;
   logic [31:0] req_file_size = '0;
   logic [31:0] req_change_time = '0;
   logic [31:0] req_now = '0;
   logic [9:0]  req_handle = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_slot;
   logic [15:0] rsp_ref_count;
   logic [10:0] rsp_freed_entries;
   logic [10:0] rsp_active_entries;
   logic [41:0] rsp_bytes_held;
   logic [17:0] rsp_age_limit;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = ract_pkg::CSR_BASE_AGE;
   logic [41:0] csr_data = '0;

   refcounted_aging_cache_table u_top (.*);

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  slot;
      logic [15:0] refs;
      logic [10:0] freed;
      logic [10:0] active;
      logic [41:0] bytes;
      logic [17:0] age;
   } cache_reply_type;

   typedef struct {
      ract_pkg::op_type op;
      logic [31:0]      f, d, s, c, now;
      logic [9:0]       h;
      logic             fixed;
      cache_reply_type  want;
   } cache_cmd_type;

   // shadow of the cache table
   bit          sh_valid[SLOTS];
   logic [31:0] sh_file[SLOTS], sh_dev[SLOTS], sh_size[SLOTS], sh_ctime[SLOTS];
   logic [31:0] sh_stamp[SLOTS];
   int unsigned sh_refs[SLOTS];
   logic [15:0] cfg_base;
   logic [41:0] cfg_max_bytes;
   logic [10:0] cfg_max_entries;
   logic [17:0] sh_age;
   int unsigned sh_entries;
   logic [41:0] sh_bytes;

   cache_reply_type pending_replies[$];
   bit              typed_flags[$];
   cache_reply_type typed_replies[$];
   int              errors = 0;
   int              outstanding = 0;
   logic [31:0]     clock_now = 32'd1000;

   // recent keys {file, device, size, ctime}, reused to get hits
   logic [127:0] key_pool[$];

   function automatic logic [9:0] hash_slot(logic [31:0] f, d, s, c);
      logic [31:0] h;
      h = 32'd177573;
      h = h ^ f;
      h = h + (h << 5);
      h = h ^ d;
      h = h + (h << 5);
      h = h ^ s;
      h = h + (h << 5);
      h = h ^ c;
      return h[9:0];
   endfunction

   function automatic cache_reply_type cache_predict(cache_cmd_type t);
      cache_reply_type r;
      int unsigned idx, n, freed;
      logic [19:0] a;
      logic [19:0] b3;
      logic [15:0] b10;
      r = '0;
      case (t.op)
         ract_pkg::OP_MAP: begin
            idx = {22'd0, hash_slot(t.f, t.d, t.s, t.c)};
            r.status = ract_pkg::ST_FULL;
            for (n = 0; n < SLOTS; n++) begin
               if (!sh_valid[idx]) begin
                  sh_valid[idx] = 1; sh_file[idx] = t.f; sh_dev[idx] = t.d;
                  sh_size[idx] = t.s; sh_ctime[idx] = t.c; sh_refs[idx] = 1;
                  sh_stamp[idx] = t.now;
                  sh_entries++;
                  sh_bytes = sh_bytes + {10'd0, t.s};
                  r.status = ract_pkg::ST_INSERTED; r.slot = 10'(idx); r.refs = 16'd1;
                  break;
               end
               if (sh_file[idx] == t.f && sh_dev[idx] == t.d && sh_size[idx] == t.s &&
                   sh_ctime[idx] == t.c) begin
                  if (sh_refs[idx] < REF_MAX) sh_refs[idx]++;
                  sh_stamp[idx] = t.now;
                  r.status = ract_pkg::ST_HIT; r.slot = 10'(idx);
                  r.refs = 16'(sh_refs[idx]);
                  break;
               end
               idx = (idx + 1) % SLOTS;
            end
         end
         ract_pkg::OP_UNMAP: begin
            if (!sh_valid[t.h]) r.status = ract_pkg::ST_NOTFOUND;
            else if (sh_refs[t.h] == 0) r.status = ract_pkg::ST_ZERO;
            else begin
               sh_refs[t.h]--;
               sh_stamp[t.h] = t.now;
               r.status = ract_pkg::ST_RELEASED; r.refs = 16'(sh_refs[t.h]);
            end
         end
         default: begin
            freed = 0;
            for (n = 0; n < SLOTS; n++)
               if (sh_valid[n] && sh_refs[n] == 0 && t.now >= sh_stamp[n] &&
                   t.now - sh_stamp[n] >= {14'd0, sh_age}) begin
                  sh_valid[n] = 0;
                  sh_entries--;
                  sh_bytes = sh_bytes - {10'd0, sh_size[n]};
                  freed++;
               end
            b10 = cfg_base / 16'd10;
            b3 = {4'd0, cfg_base} * 20'd3;
            if (sh_bytes > cfg_max_bytes || sh_entries > {21'd0, cfg_max_entries}) begin
               a = ({2'd0, sh_age} * 20'd2) / 20'd3;
               sh_age = 18'((a > {4'd0, b10}) ? a : {4'd0, b10});
            end else if (sh_entries < {22'd0, cfg_max_entries[10:1]}) begin
               a = ({2'd0, sh_age} * 20'd5) / 20'd4;
               sh_age = 18'((a < b3) ? a : b3);
            end
            r.status = ract_pkg::ST_SWEPT; r.freed = 11'(freed);
         end
      endcase
      r.active = 11'(sh_entries);
      r.bytes = sh_bytes;
      r.age = sh_age;
      return r;
   endfunction

   // one transaction, with a random gap in the idle phase
   bit gaps_on = 1;

   task automatic send_cmd(cache_cmd_type t);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= t.op; req_file_id <= t.f; req_device_id <= t.d;
      req_file_size <= t.s; req_change_time <= t.c; req_now <= t.now;
      req_handle <= t.h; start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (t.op != ract_pkg::OP_NONE) begin
         pending_replies.push_back(cache_predict(t));
         typed_flags.push_back(t.fixed);
         typed_replies.push_back(t.want);
         outstanding++;
      end
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (outstanding > 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(ract_pkg::csr_type idx, logic [41:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      case (idx)
         ract_pkg::CSR_BASE_AGE:  cfg_base = val[15:0];
         ract_pkg::CSR_MAX_BYTES: cfg_max_bytes = val;
         default:                 cfg_max_entries = val[10:0];
      endcase
   endtask

   function automatic cache_cmd_type make_cmd(ract_pkg::op_type op,
                                              logic [31:0] f, d, s, c, now,
                                              logic [9:0] h);
      cache_cmd_type t;
      t.op = op; t.f = f; t.d = d; t.s = s; t.c = c; t.now = now; t.h = h;
      t.fixed = 0; t.want = '0;
      return t;
   endfunction

   // check replies against the oldest expectation
   always @(posedge clock) begin
      cache_reply_type e, got;
      bit fx;
      cache_reply_type w;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_slot, rsp_ref_count, rsp_freed_entries,
                rsp_active_entries, rsp_bytes_held, rsp_age_limit};
         if (pending_replies.size() == 0) begin
            $error("unexpected transaction status %0d", rsp_status);
            errors++;
         end else begin
            e = pending_replies.pop_front();
            fx = typed_flags.pop_front();
            w = typed_replies.pop_front();
            if (fx) e = w;
            outstanding--;
            if (got.status != e.status) begin
               $error("status exp %0d got %0d", e.status, got.status); errors++; end
            if (got.slot != e.slot) begin
               $error("slot exp %0d got %0d", e.slot, got.slot); errors++; end
            if (got.refs != e.refs) begin
               $error("ref_count exp %0d got %0d", e.refs, got.refs); errors++; end
            if (got.freed != e.freed) begin
               $error("freed_entries exp %0d got %0d", e.freed, got.freed); errors++; end
            if (got.active != e.active) begin
               $error("active_entries exp %0d got %0d", e.active, got.active); errors++; end
            if (got.bytes != e.bytes) begin
               $error("bytes_held exp %0d got %0d", e.bytes, got.bytes); errors++; end
            if (got.age != e.age) begin
               $error("age_limit exp %0d got %0d", e.age, got.age); errors++; end
         end
      end
   end

   // run limit
   initial begin
      #400000000;
      $display("simulation failed");
      $finish;
   end

   task automatic random_map(logic [31:0] tnow);
      logic [127:0] k;
      int p;
      if (key_pool.size() > 0 && $urandom_range(0, 2) == 0) begin
         p = $urandom_range(0, key_pool.size() - 1);
         k = key_pool[p];
      end else begin
         k[127:96] = $urandom; k[95:64] = $urandom_range(0, 3);
         k[63:32] = $urandom; k[31:0] = $urandom;
         if ($urandom_range(0, 3) == 0) k[95:64] = $urandom;
         if ($urandom_range(0, 1) == 1) k[63:32] = $urandom_range(0, 100000);
         key_pool.push_back(k);
         if (key_pool.size() > 64) void'(key_pool.pop_front());
      end
      send_cmd(make_cmd(ract_pkg::OP_MAP, k[127:96], k[95:64], k[63:32], k[31:0],
                        tnow, 10'($urandom)));
   endtask

   task automatic random_unmap(logic [31:0] tnow);
      logic [9:0] h;
      logic [127:0] k;
      int p;
      h = 10'($urandom);
      if (key_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
         p = $urandom_range(0, key_pool.size() - 1);
         k = key_pool[p];
         h = hash_slot(k[127:96], k[95:64], k[63:32], k[31:0]);
      end
      send_cmd(make_cmd(ract_pkg::OP_UNMAP, $urandom, $urandom, $urandom, $urandom,
                        tnow, h));
   endtask

   // stimulus
   initial begin
      cache_cmd_type dir[$];
      cache_cmd_type t;
      int i, k, sel;
      int unsigned n_items;
      logic [41:0] v;
      logic [9:0]  hk;
      logic [31:0] snow;

      cfg_base = ract_pkg::BASE_AGE_RST; cfg_max_bytes = ract_pkg::MAX_BYTES_RST;
      cfg_max_entries = ract_pkg::MAX_ENTRY_RST;
      sh_age = 18'(ract_pkg::BASE_AGE_RST); sh_entries = 0; sh_bytes = '0;
      for (i = 0; i < SLOTS; i++) begin
         sh_valid[i] = 0; sh_refs[i] = 0;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: fixed rows first, then predictor-checked rows
      t = make_cmd(ract_pkg::OP_UNMAP, '0, '0, '0, '0, '0, 10'd0);
      t.fixed = 1;
      t.want = '{ract_pkg::ST_NOTFOUND, 10'd0, 16'd0, 11'd0, 11'd0, 42'd0, 18'd600};
      dir.push_back(t);
      t = make_cmd(ract_pkg::OP_UNMAP, '0, '0, '0, '0, '0, 10'h3FF);
      t.fixed = 1;
      t.want = '{ract_pkg::ST_NOTFOUND, 10'd0, 16'd0, 11'd0, 11'd0, 42'd0, 18'd600};
      dir.push_back(t);
      // empty sweep at reset: age grows to 750
      t = make_cmd(ract_pkg::OP_SWEEP, '0, '0, '0, '0, '0, 10'd0);
      t.fixed = 1;
      t.want = '{ract_pkg::ST_SWEPT, 10'd0, 16'd0, 11'd0, 11'd0, 42'd0, 18'd750};
      dir.push_back(t);
      dir.push_back(make_cmd(ract_pkg::OP_MAP, '1, '1, '1, '1, '1, 10'd0));
      dir.push_back(make_cmd(ract_pkg::OP_MAP, '1, '1, '1, '1, 32'd100, 10'd0));
      dir.push_back(make_cmd(ract_pkg::OP_MAP, '0, '0, '0, '0, '0, 10'd0));
      dir.push_back(make_cmd(ract_pkg::OP_MAP, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 10'd0));
      dir.push_back(make_cmd(ract_pkg::OP_NONE, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 10'd0));
      // unmap the all-ones key twice and once more into count zero
      hk = hash_slot('1, '1, '1, '1);
      dir.push_back(make_cmd(ract_pkg::OP_UNMAP, '0, '0, '0, '0, 32'd200, hk));
      dir.push_back(make_cmd(ract_pkg::OP_UNMAP, '0, '0, '0, '0, 32'd300, hk));
      dir.push_back(make_cmd(ract_pkg::OP_UNMAP, '0, '0, '0, '0, 32'd300, hk));
      // stamp after now is never expired; then real expiry
      dir.push_back(make_cmd(ract_pkg::OP_SWEEP, '0, '0, '0, '0, 32'd10, 10'd0));
      dir.push_back(make_cmd(ract_pkg::OP_SWEEP, '0, '0, '0, '0, '1, 10'd0));
      dir.push_back(make_cmd(ract_pkg::OP_MAP, 32'd7, '0, 32'd7, 32'd7, 32'd50, 10'd0));
      dir.push_back(make_cmd(ract_pkg::OP_MAP, 32'd7, '0, 32'd7, 32'd7, 32'd60, 10'd0));
      for (i = 0; i < dir.size(); i++) send_cmd(dir[i]);
      wait_idle();

      // random phases under several register settings
      for (k = 0; k < 6; k++) begin
         case (k)
            0: begin write_reg(ract_pkg::CSR_BASE_AGE, 42'd1);
                     write_reg(ract_pkg::CSR_MAX_BYTES, '0);
                     write_reg(ract_pkg::CSR_MAX_ENTRY, 42'd0); end
            1: begin write_reg(ract_pkg::CSR_BASE_AGE, 42'hFFFF);
                     write_reg(ract_pkg::CSR_MAX_BYTES, '1);
                     write_reg(ract_pkg::CSR_MAX_ENTRY, 42'd1024); end
            2: begin write_reg(ract_pkg::CSR_BASE_AGE, 42'd30);
                     write_reg(ract_pkg::CSR_MAX_BYTES, 42'd400000);
                     write_reg(ract_pkg::CSR_MAX_ENTRY, 42'd40); end
            3: begin v = 42'({$urandom, $urandom});
                     write_reg(ract_pkg::CSR_BASE_AGE, 42'($urandom_range(1, 65535)));
                     write_reg(ract_pkg::CSR_MAX_BYTES, v);
                     write_reg(ract_pkg::CSR_MAX_ENTRY, 42'($urandom_range(0, 1024))); end
            4: begin write_reg(ract_pkg::CSR_BASE_AGE, 42'd600);
                     write_reg(ract_pkg::CSR_MAX_BYTES, 42'd1000000000);
                     write_reg(ract_pkg::CSR_MAX_ENTRY, 42'd20); end
            default: write_reg(ract_pkg::CSR_BASE_AGE, 42'd100);
         endcase
         csr_write <= 1'b0;
         gaps_on = (k != 5);
         n_items = 180;
         for (i = 0; i < n_items; i++) begin
            clock_now = clock_now + $urandom_range(0, 40);
            sel = $urandom_range(0, 99);
            if (sel < 55) random_map(clock_now);
            else if (sel < 85) random_unmap(clock_now);
            else if (sel < 95) begin
               snow = ($urandom_range(0, 9) == 0) ? clock_now - 32'd500 : clock_now;
               send_cmd(make_cmd(ract_pkg::OP_SWEEP, '0, '0, '0, '0, snow, 10'd0));
            end
            else send_cmd(make_cmd(ract_pkg::OP_NONE, $urandom, $urandom, $urandom,
                                   $urandom, clock_now, 10'($urandom)));
         end
         wait_idle();
      end

      if (errors == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
